[src/cnlc_pkg.sv]
`timescale 1ns / 1ps

package cnlc_pkg;

	// Width of the binary card number.
	localparam int NUM_W = 63;

	// Decimal digits needed for the largest NUM_W-bit value (log10(2) ~ 0.30103).
	localparam int DEC_DIGITS = (NUM_W * 30103) / 100000 + 1;
	localparam int BCD_W = DEC_DIGITS * 4;

	// Binary bits consumed by each conversion stage.
	localparam int BPS = 4;
	localparam int DD_STAGES = (NUM_W + BPS - 1) / BPS;
	localparam int PAD_W = DD_STAGES * BPS;

	// Field widths.
	localparam int CNT_W = 5;
	localparam int BRAND_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 5;

	// Digit sums are formed in groups, then added in the next stage.
	localparam int GRP = 5;
	localparam int NGRP = (DEC_DIGITS + GRP - 1) / GRP;
	localparam int PSUM_W = $clog2(9 * GRP + 1);
	localparam int SUM_W = $clog2(9 * DEC_DIGITS + 1);

	// Reset values of the length limits.
	localparam logic [CNT_W-1:0] MIN_DIGITS_RST = CNT_W'(13);
	localparam logic [CNT_W-1:0] MAX_DIGITS_RST = CNT_W'(16);

	// Prefix digits used by the brand decode.
	localparam logic [3:0] DIG_ONE = 4'd1;
	localparam logic [3:0] DIG_THREE = 4'd3;
	localparam logic [3:0] DIG_FOUR = 4'd4;
	localparam logic [3:0] DIG_FIVE = 4'd5;
	localparam logic [3:0] DIG_SEVEN = 4'd7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_DIGITS = 2'd0,
		REG_MAX_DIGITS = 2'd1
	} cfg_reg_t;

	typedef enum logic [BRAND_W-1:0] {
		BRAND_INVALID  = 2'd0,
		BRAND_PREFIX4  = 2'd1,
		BRAND_PREFIX5X = 2'd2,
		BRAND_PREFIX3X = 2'd3
	} brand_t;

	// One double-dabble step: correct every BCD digit of five or more, then shift in a bit.
	function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd, input logic b);
		logic [BCD_W-1:0] adj;
		adj = bcd;
		for (int i = 0; i < DEC_DIGITS; i++) begin
			if (bcd[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
			end
		end
		return {adj[BCD_W-2:0], b};
	endfunction

	// Doubled digit with a two-digit product folded into one digit.
	function automatic logic [3:0] luhn_dbl(input logic [3:0] d);
		logic [3:0] r;
		unique case (d)
			4'd0: r = 4'd0;
			4'd1: r = 4'd2;
			4'd2: r = 4'd4;
			4'd3: r = 4'd6;
			4'd4: r = 4'd8;
			4'd5: r = 4'd1;
			4'd6: r = 4'd3;
			4'd7: r = 4'd5;
			4'd8: r = 4'd7;
			4'd9: r = 4'd9;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	// Restoring reduction by ten times powers of two; true when the sum is a multiple of ten.
	function automatic logic is_mult10(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		logic [SUM_W+3:0] k10;
		r = s;
		for (int k = SUM_W - 4; k >= 0; k--) begin
			k10 = (SUM_W + 4)'(10) << k;
			if ({4'b0000, r} >= k10) begin
				r = r - k10[SUM_W-1:0];
			end
		end
		return (r == '0);
	endfunction

endpackage

[src/cnlc_dd_stage.sv]
`timescale 1ns / 1ps

module cnlc_dd_stage
	import cnlc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [BCD_W-1:0] in_bcd,
	input  logic [PAD_W-1:0] in_bits,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [BCD_W-1:0] out_bcd,
	output logic [PAD_W-1:0] out_bits
);

	logic             valid_s1;
	logic [BCD_W-1:0] bcd_s1;
	logic [PAD_W-1:0] bits_s1;
	logic [BCD_W-1:0] bcd_nxt;

	// The stage takes a new transfer when it is empty or its content moves on.
	assign in_ready = !valid_s1 || out_ready;

	// Shift the next BPS bits of the number, most significant first, into the BCD digits.
	always_comb begin
		bcd_nxt = in_bcd;
		for (int k = 0; k < BPS; k++) begin
			bcd_nxt = dd_step(bcd_nxt, in_bits[PAD_W-1-k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			bcd_s1  <= bcd_nxt;
			bits_s1 <= in_bits << BPS;
		end
	end

	assign out_valid = valid_s1;
	assign out_bcd   = bcd_s1;
	assign out_bits  = bits_s1;

endmodule

[src/cnlc_verdict.sv]
`timescale 1ns / 1ps

module cnlc_verdict
	import cnlc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [BCD_W-1:0]   in_bcd,
	input  logic [CNT_W-1:0]   min_digits,
	input  logic [CNT_W-1:0]   max_digits,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [BRAND_W-1:0] brand,
	output logic [CNT_W-1:0]   digit_count,
	output logic               length_ok,
	output logic               luhn_ok
);

	// Stage 1: digit count, leading digits, group sums.
	logic              valid_s1;
	logic [CNT_W-1:0]  cnt_s1;
	logic [3:0]        lead_s1;
	logic [3:0]        second_s1;
	logic              has2_s1;
	logic [PSUM_W-1:0] psum_s1 [NGRP];

	// Stage 2: total sum and length check.
	logic             valid_s2;
	logic [CNT_W-1:0] cnt_s2;
	logic [3:0]       lead_s2;
	logic [3:0]       second_s2;
	logic             has2_s2;
	logic [SUM_W-1:0] sum_s2;
	logic             len_ok_s2;

	// Stage 3: Luhn verdict and brand, held as the output register.
	logic             valid_s3;
	logic [CNT_W-1:0] cnt_s3;
	logic             len_ok_s3;
	logic             luhn_ok_s3;
	brand_t           brand_s3;

	logic rdy_s1, rdy_s2, rdy_s3;

	logic [CNT_W-1:0]  cnt_c;
	logic [3:0]        lead_c;
	logic [3:0]        second_c;
	logic              has2_c;
	logic [PSUM_W-1:0] psum_c [NGRP];
	logic [SUM_W-1:0]  sum_c;
	logic              luhn_c;
	brand_t            brand_c;

	assign rdy_s3   = !valid_s3 || out_ready;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Highest nonzero digit sets the count and the leading pair; zero counts as one digit.
	always_comb begin
		cnt_c    = CNT_W'(1);
		lead_c   = in_bcd[3:0];
		second_c = 4'd0;
		has2_c   = 1'b0;
		for (int i = 1; i < DEC_DIGITS; i++) begin
			if (in_bcd[4*i +: 4] != 4'd0) begin
				cnt_c    = CNT_W'(i + 1);
				lead_c   = in_bcd[4*i +: 4];
				second_c = in_bcd[4*(i-1) +: 4];
				has2_c   = 1'b1;
			end
		end
	end

	// Luhn terms summed per group; every second digit from the right is doubled.
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			psum_c[g] = '0;
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < DEC_DIGITS) begin
					if (((g * GRP + j) % 2) == 1) begin
						psum_c[g] = psum_c[g]
							+ PSUM_W'(luhn_dbl(in_bcd[4*(g*GRP+j) +: 4]));
					end else begin
						psum_c[g] = psum_c[g] + PSUM_W'(in_bcd[4*(g*GRP+j) +: 4]);
					end
				end
			end
		end
	end

	always_comb begin
		sum_c = '0;
		for (int g = 0; g < NGRP; g++) begin
			sum_c = sum_c + SUM_W'(psum_s1[g]);
		end
	end

	// Brand decode from the leading digits, only when both checks pass.
	always_comb begin
		luhn_c  = is_mult10(sum_s2);
		brand_c = BRAND_INVALID;
		if (len_ok_s2 && luhn_c) begin
			priority if (lead_s2 == DIG_FOUR) begin
				brand_c = BRAND_PREFIX4;
			end else if (lead_s2 == DIG_FIVE && has2_s2 && second_s2 >= DIG_ONE
				&& second_s2 <= DIG_FIVE) begin
				brand_c = BRAND_PREFIX5X;
			end else if (lead_s2 == DIG_THREE && has2_s2
				&& (second_s2 == DIG_FOUR || second_s2 == DIG_SEVEN)) begin
				brand_c = BRAND_PREFIX3X;
			end else begin
				brand_c = BRAND_INVALID;
			end
		end
	end

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= in_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage payloads load only when a transfer moves into them.
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			cnt_s1    <= cnt_c;
			lead_s1   <= lead_c;
			second_s1 <= second_c;
			has2_s1   <= has2_c;
			psum_s1   <= psum_c;
		end
		if (rdy_s2 && valid_s1) begin
			cnt_s2    <= cnt_s1;
			lead_s2   <= lead_s1;
			second_s2 <= second_s1;
			has2_s2   <= has2_s1;
			sum_s2    <= sum_c;
			len_ok_s2 <= (cnt_s1 >= min_digits) && (cnt_s1 <= max_digits);
		end
		if (rdy_s3 && valid_s2) begin
			cnt_s3     <= cnt_s2;
			len_ok_s3  <= len_ok_s2;
			luhn_ok_s3 <= luhn_c;
			brand_s3   <= brand_c;
		end
	end

	assign out_valid   = valid_s3;
	assign brand       = brand_s3;
	assign digit_count = cnt_s3;
	assign length_ok   = len_ok_s3;
	assign luhn_ok     = luhn_ok_s3;

endmodule

[src/card_number_luhn_check.sv]
`timescale 1ns / 1ps

// Card number check: each card_number transfer yields one result with the decimal digit
// count, the length verdict against min_digits/max_digits, the Luhn mod-10 verdict and
// the brand (nonzero only when both checks pass). The block is fully pipelined and
// accepts one number per cycle while the output is not stalled. A result passes through
// the binary-to-decimal conversion, which shifts four bits of the number per stage,
// followed by three stages for the count and digit sums, the sum total and length
// compare, and the verdict. Backpressure on the output stalls the whole pipeline without
// loss. The limits are written through the configuration channel (index 0 minimum,
// 1 maximum; reset 13 and 16; other indexes are ignored) and should only change while no
// number is in flight.
module card_number_luhn_check
	import cnlc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [NUM_W-1:0]      card_number,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [BRAND_W-1:0]    brand,
	output logic [CNT_W-1:0]      digit_count,
	output logic                  length_ok,
	output logic                  luhn_ok,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CNT_W-1:0] min_digits_q;
	logic [CNT_W-1:0] max_digits_q;

	logic             st_valid [DD_STAGES+1];
	logic             st_ready [DD_STAGES+1];
	logic [BCD_W-1:0] st_bcd   [DD_STAGES+1];
	logic [PAD_W-1:0] st_bits  [DD_STAGES+1];

	// Configuration writes complete in the cycle they are offered.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_digits_q <= MIN_DIGITS_RST;
			max_digits_q <= MAX_DIGITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_DIGITS: min_digits_q <= cfg_data;
				REG_MAX_DIGITS: max_digits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Conversion chain input: empty BCD digits and the number zero-extended to whole stages.
	assign st_valid[0] = in_valid;
	assign in_ready    = st_ready[0];
	assign st_bcd[0]   = '0;
	assign st_bits[0]  = PAD_W'(card_number);

	for (genvar s = 0; s < DD_STAGES; s++) begin : g_dd
		cnlc_dd_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (st_valid[s]),
			.in_ready  (st_ready[s]),
			.in_bcd    (st_bcd[s]),
			.in_bits   (st_bits[s]),
			.out_valid (st_valid[s+1]),
			.out_ready (st_ready[s+1]),
			.out_bcd   (st_bcd[s+1]),
			.out_bits  (st_bits[s+1])
		);
	end

	// Count, sums and verdict on the finished decimal digits.
	cnlc_verdict u_verdict (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (st_valid[DD_STAGES]),
		.in_ready    (st_ready[DD_STAGES]),
		.in_bcd      (st_bcd[DD_STAGES]),
		.min_digits  (min_digits_q),
		.max_digits  (max_digits_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.brand       (brand),
		.digit_count (digit_count),
		.length_ok   (length_ok),
		.luhn_ok     (luhn_ok)
	);

endmodule

[src/cnlc_sva.sv]
`timescale 1ns / 1ps

module cnlc_sva
	import cnlc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [NUM_W-1:0]      card_number,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [BRAND_W-1:0]    brand,
	input logic [CNT_W-1:0]      digit_count,
	input logic                  length_ok,
	input logic                  luhn_ok,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// A stalled result holds its value until the transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable(brand) && $stable(digit_count) && $stable(length_ok) && $stable(luhn_ok))
		else $error("stalled result changed");

	// A brand is reported only for a number that passed both checks.
	a_brand_checked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && brand != BRAND_INVALID |-> length_ok && luhn_ok)
		else $error("brand given for a failed number");

	// The digit count always lies between one and the widest possible number.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> digit_count >= CNT_W'(1) && digit_count <= CNT_W'(DEC_DIGITS))
		else $error("digit count out of range");

	// A single-digit number can only carry the one-digit prefix brand.
	a_single_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && digit_count == CNT_W'(1) |->
			brand == BRAND_INVALID || brand == BRAND_PREFIX4)
		else $error("two-digit prefix brand on a single digit");

endmodule

bind card_number_luhn_check cnlc_sva u_cnlc_sva (.*);
